FILE: rtl/qcm_pkg.sv
// Shared widths, types and fixed-point helpers for the quaternion-to-matrix core.
package qcm_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = COMP_WIDTH - 1;
  localparam int PROD_W     = 2 * COMP_WIDTH;
  localparam int SUM_W      = PROD_W + 2;
  localparam int SHR_W      = SUM_W + 1 - FRAC_BITS;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [1:0]                   row_t;

  localparam row_t ROW_0 = 2'd0;
  localparam row_t ROW_1 = 2'd1;
  localparam row_t ROW_2 = 2'd2;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  // Round an exact Q.2F sum to Q.F (ties toward plus infinity) and saturate.
  function automatic comp_t round_sat(input sum_t s);
    logic signed [SUM_W:0]                   t;
    logic signed [SHR_W-1:0]                 sh;
    logic [SHR_W-COMP_WIDTH:0]               hi;
    comp_t                                   r;
    t  = {s[SUM_W-1], s} + (SUM_W+1)'(1 << (FRAC_BITS - 1));
    sh = t[SUM_W:FRAC_BITS];
    hi = sh[SHR_W-1:COMP_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      r = sh[COMP_WIDTH-1:0];
    end else if (sh[SHR_W-1]) begin
      r = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: rtl/qcm_in_if.sv
// Input channel: two quaternions with valid/ready handshake.
interface qcm_in_if;
  import qcm_pkg::*;

  logic  valid;
  logic  ready;
  comp_t a_w;
  comp_t a_x;
  comp_t a_y;
  comp_t a_z;
  comp_t b_w;
  comp_t b_x;
  comp_t b_y;
  comp_t b_z;

  modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

FILE: rtl/qcm_out_if.sv
// Result channel: one rotation matrix row plus the product quaternion.
interface qcm_out_if;
  import qcm_pkg::*;

  logic  valid;
  logic  ready;
  row_t  row;
  comp_t col0;
  comp_t col1;
  comp_t col2;
  comp_t p_w;
  comp_t p_x;
  comp_t p_y;
  comp_t p_z;
  logic  last;

  modport source (output valid, row, col0, col1, col2, p_w, p_x, p_y, p_z, last,
                  input ready);
  modport sink   (input valid, row, col0, col1, col2, p_w, p_x, p_y, p_z, last,
                  output ready);
endinterface

FILE: rtl/quaternion_compose_to_matrix_core.sv
// Top level: Hamilton product of two quaternions and the rotation matrix of the product.
//
// in_ch carries two Q1.15 quaternions a and b per item (valid/ready). For each
// item out_ch delivers three items in row order 0, 1, 2: the matrix row, the
// saturated product quaternion (same in all three) and last set on row 2.
// Row 0 passes the partial-product, product, queue, back-end product and output
// registers; rows 1 and 2 follow in the next cycles when ready stays high.
// The back end takes a new item only as row 2 leaves and emits one row per
// cycle while ready is high, from a single set of ten registered products.
// The front end (16 multipliers, then sum and rounding) runs at one item per
// cycle while its two-entry queue has room; in_ch.ready falls only once that
// queue and the front pipeline are full.
// A stalled receiver holds the output register; the back end, queue and front
// end then fill up in turn without losing or repeating an item.
// Reset (rst_n low, synchronous) empties pipeline, queue and output register;
// no item is in flight afterwards and nothing is kept between items.
module quaternion_compose_to_matrix_core (
  input  logic      clk,
  input  logic      rst_n,
  qcm_in_if.sink    in_ch,
  qcm_out_if.source out_ch
);
  import qcm_pkg::*;

  logic  f_valid;
  quat_t f_data;
  logic  f_ready;
  logic  q_valid;
  quat_t q_data;
  logic  q_ready;

  qcm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready)
  );

  qcm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .pop_ready  (q_ready)
  );

  qcm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop_ready (q_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/qcm_front.sv
// Front end: accepts items and forms the Hamilton product in two stages.
module qcm_front (
  input  logic          clk,
  input  logic          rst_n,
  qcm_in_if.sink        in_ch,
  output logic          push_valid,
  output qcm_pkg::quat_t push_data,
  input  logic          push_ready
);
  import qcm_pkg::*;

  logic  v1_r;
  logic  v2_r;
  prod_t prod_r [16];
  quat_t p_r;
  logic  en1;
  logic  en2;
  sum_t  sw;
  sum_t  sx;
  sum_t  sy;
  sum_t  sz;

  assign en2         = !v2_r || push_ready;
  assign en1         = !v1_r || en2;
  assign in_ch.ready = en1;
  assign push_valid  = v2_r;
  assign push_data   = p_r;

  always_comb begin
    sw = sum_t'(prod_r[0])  - sum_t'(prod_r[1])  - sum_t'(prod_r[2])  - sum_t'(prod_r[3]);
    sx = sum_t'(prod_r[4])  + sum_t'(prod_r[5])  + sum_t'(prod_r[6])  - sum_t'(prod_r[7]);
    sy = sum_t'(prod_r[8])  - sum_t'(prod_r[9])  + sum_t'(prod_r[10]) + sum_t'(prod_r[11]);
    sz = sum_t'(prod_r[12]) + sum_t'(prod_r[13]) - sum_t'(prod_r[14]) + sum_t'(prod_r[15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // Sixteen partial products, registered before the sums.
  always_ff @(posedge clk) begin
    if (en1 && in_ch.valid) begin
      prod_r[0]  <= in_ch.a_w * in_ch.b_w;
      prod_r[1]  <= in_ch.a_x * in_ch.b_x;
      prod_r[2]  <= in_ch.a_y * in_ch.b_y;
      prod_r[3]  <= in_ch.a_z * in_ch.b_z;
      prod_r[4]  <= in_ch.a_w * in_ch.b_x;
      prod_r[5]  <= in_ch.a_x * in_ch.b_w;
      prod_r[6]  <= in_ch.a_y * in_ch.b_z;
      prod_r[7]  <= in_ch.a_z * in_ch.b_y;
      prod_r[8]  <= in_ch.a_w * in_ch.b_y;
      prod_r[9]  <= in_ch.a_x * in_ch.b_z;
      prod_r[10] <= in_ch.a_y * in_ch.b_w;
      prod_r[11] <= in_ch.a_z * in_ch.b_x;
      prod_r[12] <= in_ch.a_w * in_ch.b_z;
      prod_r[13] <= in_ch.a_x * in_ch.b_y;
      prod_r[14] <= in_ch.a_y * in_ch.b_x;
      prod_r[15] <= in_ch.a_z * in_ch.b_w;
    end
    if (en2 && v1_r) begin
      p_r.w <= round_sat(sw);
      p_r.x <= round_sat(sx);
      p_r.y <= round_sat(sy);
      p_r.z <= round_sat(sz);
    end
  end

endmodule

FILE: rtl/qcm_fifo.sv
// Short queue of product quaternions between front and back ends.
module qcm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  qcm_pkg::quat_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output qcm_pkg::quat_t pop_data,
  input  logic           pop_ready
);
  import qcm_pkg::*;

  quat_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/qcm_back.sv
// Back end: squares/cross products of the product; one matrix row a cycle if ready.
module qcm_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  input  qcm_pkg::quat_t pop_data,
  output logic           pop_ready,
  qcm_out_if.source      out_ch
);
  import qcm_pkg::*;

  logic  va_r;
  row_t  row_r;
  quat_t qa_r;
  prod_t ww_r, xx_r, yy_r, zz_r, xy_r, wx_r, wy_r, yz_r, wz_r, xz_r;
  logic  vo_r;
  row_t  o_row_r;
  comp_t o_c0_r, o_c1_r, o_c2_r;
  quat_t o_p_r;
  logic  o_last_r;
  logic  adv;
  logic  load_a;
  sum_t  s0, s1, s2;

  assign adv       = !vo_r || out_ch.ready;
  assign load_a    = !va_r || (adv && (row_r == ROW_2));
  assign pop_ready = load_a;

  always_comb begin
    unique case (row_r)
      ROW_0: begin
        s0 = sum_t'(ww_r) + sum_t'(xx_r) - sum_t'(yy_r) - sum_t'(zz_r);
        s1 = sum_t'(xy_r) + sum_t'(xy_r) - sum_t'(wz_r) - sum_t'(wz_r);
        s2 = sum_t'(xz_r) + sum_t'(xz_r) + sum_t'(wy_r) + sum_t'(wy_r);
      end
      ROW_1: begin
        s0 = sum_t'(xy_r) + sum_t'(xy_r) + sum_t'(wz_r) + sum_t'(wz_r);
        s1 = sum_t'(ww_r) - sum_t'(xx_r) + sum_t'(yy_r) - sum_t'(zz_r);
        s2 = sum_t'(yz_r) + sum_t'(yz_r) - sum_t'(wx_r) - sum_t'(wx_r);
      end
      ROW_2: begin
        s0 = sum_t'(xz_r) + sum_t'(xz_r) - sum_t'(wy_r) - sum_t'(wy_r);
        s1 = sum_t'(yz_r) + sum_t'(yz_r) + sum_t'(wx_r) + sum_t'(wx_r);
        s2 = sum_t'(ww_r) - sum_t'(xx_r) - sum_t'(yy_r) + sum_t'(zz_r);
      end
      default: begin
        s0 = '0;
        s1 = '0;
        s2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      row_r <= ROW_0;
      vo_r  <= 1'b0;
    end else begin
      if (load_a) begin
        va_r  <= pop_valid;
        row_r <= ROW_0;
      end else if (adv) begin
        row_r <= row_r + 1'b1;
      end
      if (adv) vo_r <= va_r;
    end
  end

  // Hold the products for three rows; take the next item as row two leaves.
  always_ff @(posedge clk) begin
    if (load_a && pop_valid) begin
      qa_r <= pop_data;
      ww_r <= pop_data.w * pop_data.w;
      xx_r <= pop_data.x * pop_data.x;
      yy_r <= pop_data.y * pop_data.y;
      zz_r <= pop_data.z * pop_data.z;
      xy_r <= pop_data.x * pop_data.y;
      wx_r <= pop_data.w * pop_data.x;
      wy_r <= pop_data.w * pop_data.y;
      yz_r <= pop_data.y * pop_data.z;
      wz_r <= pop_data.w * pop_data.z;
      xz_r <= pop_data.x * pop_data.z;
    end
    if (adv && va_r) begin
      o_row_r  <= row_r;
      o_c0_r   <= round_sat(s0);
      o_c1_r   <= round_sat(s1);
      o_c2_r   <= round_sat(s2);
      o_p_r    <= qa_r;
      o_last_r <= (row_r == ROW_2);
    end
  end

  assign out_ch.valid = vo_r;
  assign out_ch.row   = o_row_r;
  assign out_ch.col0  = o_c0_r;
  assign out_ch.col1  = o_c1_r;
  assign out_ch.col2  = o_c2_r;
  assign out_ch.p_w   = o_p_r.w;
  assign out_ch.p_x   = o_p_r.x;
  assign out_ch.p_y   = o_p_r.y;
  assign out_ch.p_z   = o_p_r.z;
  assign out_ch.last  = o_last_r;

endmodule
